// ===== rtl/core/csvt_pkg.sv =====
// Shared types and constants of the CSV field tokenizer.
package csvt_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [15:0] MAX_CHARS_RESET = 16'd255;

  localparam logic KIND_CONTENT   = 1'b0;
  localparam logic KIND_FIELD_END = 1'b1;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QUOTE_SEEN,
    MODE_DROP
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  column_index;
    logic [23:0] row_index;
    logic [15:0] field_length;
    logic        row_end;
    logic        truncated;
    logic        open_quote_error;
    logic        last_result;
  } out_item_t;

  // Work handed from the classifier to the counter side.
  typedef struct packed {
    logic       has_content;
    logic [7:0] data;
    logic       has_sep;
    logic       sep_nl;
    logic       has_eoi_end;
    logic       oqe;
    logic       clear;
  } op_t;

endpackage

// ===== rtl/core/csvt_front.sv =====
// Front end: accepts raw words, tracks quoting mode and classifies each byte.
module csvt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csvt_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output csvt_pkg::op_t     q_op
);
  import csvt_pkg::*;

  mode_t mode_r;
  mode_t mode_nxt;
  mode_t mode_after;
  logic  accept;
  logic  is_q;
  logic  is_sep;
  logic  is_nl;
  logic  cont;
  logic  sep_end;
  logic  eoi_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_q     = (in_data.in_byte == CH_QUOTE);
  assign is_nl    = (in_data.in_byte == CH_NL);
  assign is_sep   = (in_data.in_byte == CH_COMMA) || is_nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    mode_after = mode_r;
    cont       = 1'b0;
    case (mode_r)
      MODE_QUOTED: begin
        if (is_q) mode_after = MODE_QUOTE_SEEN;
        else      cont = 1'b1;
      end
      MODE_QUOTE_SEEN: begin
        if (is_q) begin
          cont       = 1'b1;
          mode_after = MODE_QUOTED;
        end else if (!is_sep) begin
          mode_after = MODE_DROP;
        end
      end
      MODE_START: begin
        if (is_q) begin
          mode_after = MODE_QUOTED;
        end else if (!is_sep) begin
          cont       = 1'b1;
          mode_after = MODE_PLAIN;
        end
      end
      MODE_DROP: begin
        mode_after = MODE_DROP;
      end
      MODE_PLAIN: begin
        if (!is_sep) cont = 1'b1;
      end
      default: begin
        mode_after = MODE_START;
      end
    endcase

    // separators inside an open quote are content
    sep_end = is_sep && (mode_after != MODE_QUOTED);
    eoi_end = in_data.end_of_input && !(sep_end && is_nl);

    mode_nxt = mode_r;
    if (accept) begin
      if (sep_end || in_data.end_of_input) mode_nxt = MODE_START;
      else                                 mode_nxt = mode_after;
    end

    q_op.has_content = cont;
    q_op.data        = in_data.in_byte;
    q_op.has_sep     = sep_end;
    q_op.sep_nl      = is_nl;
    q_op.has_eoi_end = eoi_end;
    q_op.oqe         = (mode_after == MODE_QUOTED);
    q_op.clear       = in_data.end_of_input;

    // drop words that leave nothing for the counters
    q_push = accept && (cont || sep_end || in_data.end_of_input);
  end

endmodule

// ===== rtl/core/csvt_queue.sv =====
// Short queue of classified operations between front and back.
module csvt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csvt_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output csvt_pkg::op_t head_op
);
  import csvt_pkg::*;

  op_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r;
  logic [QPTR_W-1:0]  rptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop)        rptr_r <= rptr_r + QPTR_W'(1);
      if ((push && !full) && !do_pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (!(push && !full) && do_pop) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/csvt_back.sv =====
// Back end: keeps row, column and length counters and emits result words.
module csvt_back #(
  parameter int unsigned COL_BITS = 8,
  parameter int unsigned ROW_BITS = 24,
  parameter int unsigned LEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  csvt_pkg::op_t      q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output csvt_pkg::out_item_t out_data
);
  import csvt_pkg::*;

  logic [15:0]         max_r;
  logic [COL_BITS-1:0] col_r, col_nxt, col_inc;
  logic [ROW_BITS-1:0] row_r, row_nxt, row_inc;
  logic [LEN_BITS-1:0] len_r, len_nxt, len_inc;
  logic                trunc_r, trunc_nxt;
  logic                phase_r, phase_nxt;
  logic                out_valid_r;
  out_item_t           out_r;
  out_item_t           res;
  logic                emit;
  logic                work;
  logic                room;
  logic                do_clear;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign work = q_valid && (!out_valid_r || out_ready);
  assign room = (32'(len_r) < 32'(max_r));

  assign col_inc = (col_r == '1) ? col_r : col_r + COL_BITS'(1);
  assign row_inc = (row_r == '1) ? row_r : row_r + ROW_BITS'(1);
  assign len_inc = (len_r == '1) ? len_r : len_r + LEN_BITS'(1);

  always_comb begin
    emit      = 1'b0;
    q_pop     = 1'b0;
    do_clear  = 1'b0;
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    len_nxt   = len_r;
    trunc_nxt = trunc_r;

    res.kind             = KIND_FIELD_END;
    res.data_byte        = 8'd0;
    res.column_index     = 8'(col_r);
    res.row_index        = 24'(row_r);
    res.field_length     = 16'(len_r);
    res.row_end          = 1'b1;
    res.truncated        = trunc_r;
    res.open_quote_error = q_op.oqe;
    res.last_result      = 1'b0;

    if (work) begin
      if (phase_r) begin
        // trailing field end for end of input
        emit      = 1'b1;
        q_pop     = 1'b1;
        do_clear  = 1'b1;
        phase_nxt = 1'b0;
      end else if (q_op.has_content) begin
        len_nxt = len_inc;
        if (room) begin
          emit                 = 1'b1;
          res.kind             = KIND_CONTENT;
          res.data_byte        = q_op.data;
          res.field_length     = 16'd0;
          res.row_end          = 1'b0;
          res.truncated        = 1'b0;
          res.open_quote_error = 1'b0;
          if (q_op.has_eoi_end) phase_nxt = 1'b1;
          else                  q_pop = 1'b1;
        end else begin
          trunc_nxt = 1'b1;
          q_pop     = 1'b1;
          if (q_op.has_eoi_end) begin
            emit             = 1'b1;
            res.field_length = 16'(len_inc);
            res.truncated    = 1'b1;
            do_clear         = 1'b1;
          end
        end
      end else if (q_op.has_sep) begin
        emit                 = 1'b1;
        res.row_end          = q_op.sep_nl;
        res.open_quote_error = 1'b0;
        len_nxt              = '0;
        trunc_nxt            = 1'b0;
        if (q_op.sep_nl) begin
          row_nxt = row_inc;
          col_nxt = '0;
        end else begin
          col_nxt = col_inc;
        end
        if (q_op.has_eoi_end) begin
          phase_nxt = 1'b1;
        end else begin
          q_pop    = 1'b1;
          do_clear = q_op.clear;
        end
      end else if (q_op.has_eoi_end) begin
        emit     = 1'b1;
        q_pop    = 1'b1;
        do_clear = 1'b1;
      end else begin
        q_pop = 1'b1;
      end
    end

    res.last_result = q_pop;

    // restart all counters after the last byte of a text
    if (do_clear) begin
      col_nxt   = '0;
      row_nxt   = '0;
      len_nxt   = '0;
      trunc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_CHARS_RESET;
      col_r       <= '0;
      row_r       <= '0;
      len_r       <= '0;
      trunc_r     <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_r <= cfg_data;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      len_r   <= len_nxt;
      trunc_r <= trunc_nxt;
      phase_r <= phase_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= res;
  end

endmodule

// ===== rtl/core/csv_field_tokenizer_unit.sv =====
// With the queue empty, the first result word of an input word is written into the operation
// queue on acceptance and then registered in the output register, where it waits for out_ready.
// Throughput: one input word per cycle while the queue is not full; a word that yields two
// results holds the back end for both of them, buffered by a four-entry operation queue.
// Opening quotes and dropped bytes do not enter the queue unless they end the input.
// Reset (synchronous, active low) clears mode, counters and queue; max_chars returns to 255.
module csv_field_tokenizer_unit #(
  parameter int unsigned COL_BITS = 8,
  parameter int unsigned ROW_BITS = 24,
  parameter int unsigned LEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csvt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csvt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import csvt_pkg::*;

  logic q_full;
  logic q_push;
  op_t  push_op;
  logic q_pop;
  logic q_valid;
  op_t  head_op;

  csvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  csvt_back #(
    .COL_BITS (COL_BITS),
    .ROW_BITS (ROW_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
